@@ sv/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/etp_pkg.sv @@
// Package with the shared types and constants of the escape tag and telnet parser.
`timescale 1ns / 1ps
package etp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int TOP_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] B_ESC  = 8'h1B;
    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_GA   = 8'hF9;
    localparam logic [7:0] B_LT   = 8'h3C;
    localparam logic [7:0] B_GT   = 8'h3E;
    localparam logic [7:0] B_BAR  = 8'h7C;
    localparam logic [7:0] B_ZERO = 8'h30;
    localparam logic [7:0] B_NINE = 8'h39;

    localparam logic [6:0] PROMPT_CODE = 7'd10;

    typedef enum logic [2:0] {
        K_TEXT    = 3'd0,
        K_TAGTEXT = 3'd1,
        K_ARGEND  = 3'd2,
        K_OPEN    = 3'd3,
        K_CLOSE   = 3'd4,
        K_TEL2    = 3'd5,
        K_TEL3    = 3'd6,
        K_PROMPT  = 3'd7
    } t_kind;

    typedef enum logic [12:0] {
        M_TEXT    = 13'b0000000000001,
        M_ESC     = 13'b0000000000010,
        M_OPEN    = 13'b0000000000100,
        M_OPEN_N  = 13'b0000000001000,
        M_CLOSE   = 13'b0000000010000,
        M_CLOSE_N = 13'b0000000100000,
        M_IAC     = 13'b0000001000000,
        M_WILL    = 13'b0000010000000,
        M_WONT    = 13'b0000100000000,
        M_DO      = 13'b0001000000000,
        M_DONT    = 13'b0010000000000,
        M_PTAG    = 13'b0100000000000,
        M_PIAC    = 13'b1000000000000
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] text;
        logic [7:0] cmd;
        logic [7:0] opt;
        logic [6:0] code;
        logic       last;
    } t_result;

endpackage

@@ sv/etp_front.sv @@
// Front end: accepts stream bytes, runs the parse state and the tag stack, pushes results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module etp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_full,
    output logic             o_push,
    output etp_pkg::t_result o_res
);
    import etp_pkg::*;

    t_mode                r_mode, n_mode;
    logic [3:0]           r_acc, n_acc;
    logic [DEPTH_W-1:0]   r_depth;
    logic [6:0]           r_stack [STACK_DEPTH];
    t_result              r_pend;
    logic                 r_pend_valid;

    logic                 accept;
    logic                 emit0, emit1, do_open, do_close, in_tag, is_dig;
    t_result              res0, res1;
    logic [3:0]           digit;
    logic [6:0]           code, top_code;
    logic [DEPTH_W-1:0]   depth_m1;

    function automatic t_result mk(t_kind k, logic [7:0] t, logic [7:0] cm,
                                   logic [7:0] op, logic [6:0] cd);
        t_result r;
        r.kind = k;
        r.text = t;
        r.cmd  = cm;
        r.opt  = op;
        r.code = cd;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_text(logic [7:0] b, logic tg);
        return mk(tg ? K_TAGTEXT : K_TEXT, b, 8'd0, 8'd0, 7'd0);
    endfunction

    function automatic t_mode text_next(logic [7:0] c);
        if (c == B_ESC) return M_ESC;
        if (c == B_IAC) return M_IAC;
        return M_TEXT;
    endfunction

    function automatic t_mode iac_next(logic [7:0] c);
        if (c == B_WILL) return M_WILL;
        if (c == B_WONT) return M_WONT;
        if (c == B_DO)   return M_DO;
        if (c == B_DONT) return M_DONT;
        return M_TEXT;
    endfunction

    function automatic logic iac_emits(logic [7:0] c);
        return !(c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT);
    endfunction

    function automatic t_result iac_result(logic [7:0] c, logic tg);
        if (c == B_IAC) return mk_text(B_IAC, tg);
        return mk(K_TEL2, 8'd0, c, 8'd0, 7'd0);
    endfunction

    assign o_ready  = !r_pend_valid && !i_full;
    assign accept   = i_valid && o_ready;
    assign in_tag   = (r_depth != '0);
    assign is_dig   = (i_rx_byte >= B_ZERO) && (i_rx_byte <= B_NINE);
    assign digit    = i_rx_byte[3:0];
    assign code     = 7'({3'd0, r_acc}) * 7'd10 + 7'({3'd0, digit});
    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign top_code = r_stack[depth_m1[TOP_W-1:0]];

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        emit0    = 1'b0;
        emit1    = 1'b0;
        res0     = '0;
        res1     = '0;
        do_open  = 1'b0;
        do_close = 1'b0;
        unique case (r_mode)
            M_ESC: begin
                if (i_rx_byte == B_LT) begin
                    n_mode = M_OPEN;
                end else if (i_rx_byte == B_GT) begin
                    n_mode = M_CLOSE;
                end else if (i_rx_byte == B_BAR) begin
                    n_mode = M_TEXT;
                    emit0  = 1'b1;
                    res0   = mk(K_ARGEND, 8'd0, 8'd0, 8'd0, 7'd0);
                end else begin
                    // A lone ESC is text, and the byte after it is parsed afresh from the text state.
                    emit0  = 1'b1;
                    res0   = mk_text(B_ESC, in_tag);
                    n_mode = text_next(i_rx_byte);
                    emit1  = (n_mode == M_TEXT);
                    res1   = mk_text(i_rx_byte, in_tag);
                end
            end
            M_OPEN, M_CLOSE: begin
                if (!is_dig) begin
                    n_mode = M_TEXT;
                    n_acc  = 4'd0;
                end else begin
                    n_acc  = digit;
                    n_mode = (r_mode == M_OPEN) ? M_OPEN_N : M_CLOSE_N;
                end
            end
            M_OPEN_N: begin
                n_mode = M_TEXT;
                n_acc  = 4'd0;
                if (is_dig && (r_depth < DEPTH_W'(STACK_DEPTH))) begin
                    do_open = 1'b1;
                    emit0   = 1'b1;
                    res0    = mk(K_OPEN, 8'd0, 8'd0, 8'd0, code);
                end
            end
            M_CLOSE_N: begin
                n_mode = M_TEXT;
                n_acc  = 4'd0;
                if (is_dig) begin
                    if (code == PROMPT_CODE) begin
                        n_mode = M_PTAG;
                    end
                    if (in_tag && (top_code == code)) begin
                        do_close = 1'b1;
                        emit0    = 1'b1;
                        res0     = mk(K_CLOSE, 8'd0, 8'd0, 8'd0, code);
                    end
                end
            end
            M_IAC: begin
                n_mode = iac_next(i_rx_byte);
                emit0  = iac_emits(i_rx_byte);
                res0   = iac_result(i_rx_byte, in_tag);
            end
            M_WILL: begin
                n_mode = M_TEXT;
                emit0  = 1'b1;
                res0   = mk(K_TEL3, 8'd0, B_WILL, i_rx_byte, 7'd0);
            end
            M_WONT: begin
                n_mode = M_TEXT;
                emit0  = 1'b1;
                res0   = mk(K_TEL3, 8'd0, B_WONT, i_rx_byte, 7'd0);
            end
            M_DO: begin
                n_mode = M_TEXT;
                emit0  = 1'b1;
                res0   = mk(K_TEL3, 8'd0, B_DO, i_rx_byte, 7'd0);
            end
            M_DONT: begin
                n_mode = M_TEXT;
                emit0  = 1'b1;
                res0   = mk(K_TEL3, 8'd0, B_DONT, i_rx_byte, 7'd0);
            end
            M_PTAG: begin
                if (i_rx_byte == B_IAC) begin
                    n_mode = M_PIAC;
                end else begin
                    n_mode = text_next(i_rx_byte);
                    emit0  = (n_mode == M_TEXT);
                    res0   = mk_text(i_rx_byte, in_tag);
                end
            end
            M_PIAC: begin
                if (i_rx_byte == B_GA) begin
                    n_mode = M_TEXT;
                    emit0  = 1'b1;
                    res0   = mk(K_PROMPT, 8'd0, 8'd0, 8'd0, 7'd0);
                end else begin
                    n_mode = iac_next(i_rx_byte);
                    emit0  = iac_emits(i_rx_byte);
                    res0   = iac_result(i_rx_byte, in_tag);
                end
            end
            default: begin
                n_mode = text_next(i_rx_byte);
                emit0  = (n_mode == M_TEXT);
                res0   = mk_text(i_rx_byte, in_tag);
            end
        endcase
        res0.last = !emit1;
    end

    // A held second result goes first; no byte is taken while one is held.
    assign o_push = (r_pend_valid && !i_full) || (accept && emit0);
    assign o_res  = r_pend_valid ? r_pend : res0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_TEXT;
            r_acc        <= 4'd0;
            r_depth      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_pend_valid && !i_full) begin
                r_pend_valid <= 1'b0;
            end
            if (accept) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                if (emit1) begin
                    r_pend_valid <= 1'b1;
                end
                if (do_open) begin
                    r_depth <= r_depth + DEPTH_W'(1);
                end else if (do_close) begin
                    r_depth <= depth_m1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit1) begin
            r_pend <= res1;
        end
        if (accept && do_open) begin
            r_stack[r_depth[TOP_W-1:0]] <= code;
        end
    end

    `ASSERT_NEVER(a_no_take_while_held, i_clk, i_rst_n, r_pend_valid && o_ready,
        "byte taken while a second result is held")
    `ASSERT_NEVER(a_depth_bound, i_clk, i_rst_n, r_depth > DEPTH_W'(STACK_DEPTH),
        "tag stack depth beyond its size")
    `ASSERT_CLK(a_split_holds, i_clk, i_rst_n,
        (accept && emit0 && !res0.last) |=> r_pend_valid,
        "first of two results pushed without the second held")
endmodule

@@ sv/etp_queue.sv @@
// Short result queue between the parser front end and the output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module etp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  etp_pkg::t_result i_res,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output etp_pkg::t_result o_head
);
    import etp_pkg::*;

    t_result            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
        return p + QPTR_W'(1);
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full,
        "result pushed into a full queue")
    `ASSERT_CLK(a_count_tracks, i_clk, i_rst_n,
        (i_push && !o_full && !(i_pop && !o_empty)) |=> (r_count != '0),
        "queue count lost a pushed result")
endmodule

@@ sv/etp_back.sv @@
// Back end: output register that presents queued results on the result channel.
`timescale 1ns / 1ps
module etp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  etp_pkg::t_result i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output etp_pkg::t_result o_res
);
    import etp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Load a new result whenever the register is empty or being emptied.
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end
endmodule

@@ sv/escape_tag_and_telnet_parser_top.sv @@
// Top level of the escape tag and telnet stream parser.
`timescale 1ns / 1ps
// The parser takes one received byte per item on the input channel and gives
// zero, one or two result items per byte on the result channel, in stream
// order, with o_last_of_run set on the final result of each byte. Bytes are
// taken at one per cycle while the queue has room and no second result is
// held; a lone ESC followed by a text byte yields two results, which leave the
// front end one per cycle through a single queue write port while the queue
// has room; no byte is taken while the second is held. The front end holds
// the parse state and a tag stack of etp_pkg::STACK_DEPTH entries, and writes
// results into a four-entry queue; an output register reads that queue, so a
// result passes through a queue entry and the output register before it is
// presented. The input side runs on while the result side stalls, until the
// queue fills. Text inside an open tag comes out as tag text. Stack entries
// are not cleared at reset; only those below the stack depth are ever read.
module escape_tag_and_telnet_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_text_byte,
    output logic [7:0] o_telnet_command,
    output logic [7:0] o_telnet_option,
    output logic [6:0] o_tag_code,
    output logic       o_last_of_run
);
    import etp_pkg::*;

    logic    push, full, pop, empty;
    t_result push_res, head_res, out_res;

    // Parse state, tag stack and the hold register for a second result.
    etp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push),
        .o_res     (push_res)
    );

    // Decouples the parser from stalls on the result channel.
    etp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_res)
    );

    // Registered result channel.
    etp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_res),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_event_kind     = out_res.kind;
    assign o_text_byte      = out_res.text;
    assign o_telnet_command = out_res.cmd;
    assign o_telnet_option  = out_res.opt;
    assign o_tag_code       = out_res.code;
    assign o_last_of_run    = out_res.last;
endmodule

@@ tb/escape_tag_and_telnet_parser_top_tb.sv @@
// Self-checking testbench for the escape tag and telnet stream parser.
`timescale 1ns / 1ps
module escape_tag_and_telnet_parser_top_tb;
    import etp_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    // One row of stimulus: the byte, and optionally the one result it must
    // give, typed in by hand. Rows without a typed result go to the predictor.
    typedef struct {
        logic [7:0] rx;
        bit         fixed;
        bit         has_ev;
        t_result    ev;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_event_kind;
    logic [7:0] o_text_byte;
    logic [7:0] o_telnet_command;
    logic [7:0] o_telnet_option;
    logic [6:0] o_tag_code;
    logic       o_last_of_run;

    // Predicted parser state.
    t_mode      pm_mode;
    logic [6:0] pm_code;
    logic [6:0] pm_stack [STACK_DEPTH];
    int         pm_depth;

    t_result    fresh_events[$];
    t_result    pending_events[$];
    t_stim_row  plan_q[$];
    t_stim_row  directed [27];

    int  error_count = 0;
    int  sent_items = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;

    escape_tag_and_telnet_parser_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_kind     (o_event_kind),
        .o_text_byte      (o_text_byte),
        .o_telnet_command (o_telnet_command),
        .o_telnet_option  (o_telnet_option),
        .o_tag_code       (o_tag_code),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic t_stim_row row(input logic [7:0] b, input bit fixed = 1'b0,
                                      input bit has = 1'b0, input t_kind k = K_TEXT,
                                      input logic [7:0] tx = 8'h00,
                                      input logic [7:0] cmd = 8'h00,
                                      input logic [7:0] opt = 8'h00,
                                      input logic [6:0] cd = 7'd0);
        t_stim_row r;
        r.rx        = b;
        r.fixed     = fixed;
        r.has_ev    = has;
        r.ev.kind   = k;
        r.ev.text   = tx;
        r.ev.cmd    = cmd;
        r.ev.opt    = opt;
        r.ev.code   = cd;
        r.ev.last   = has;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: parses one byte and appends the events it gives to
    // fresh_events, in stream order.
    // ------------------------------------------------------------------
    function automatic bit is_dec_char(input logic [7:0] c);
        return c >= B_ZERO && c <= B_NINE;
    endfunction

    function automatic void add_event(input t_kind k, input logic [7:0] tx,
                                      input logic [7:0] cmd, input logic [7:0] opt,
                                      input logic [6:0] cd);
        t_result ev;
        ev.kind = k;
        ev.text = tx;
        ev.cmd  = cmd;
        ev.opt  = opt;
        ev.code = cd;
        ev.last = 1'b0;
        fresh_events.push_back(ev);
    endfunction

    // Text inside an open tag is marked as tag text.
    function automatic void add_text(input logic [7:0] c);
        add_event((pm_depth > 0) ? K_TAGTEXT : K_TEXT, c, 8'h00, 8'h00, 7'd0);
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (c == B_ESC)
            pm_mode = M_ESC;
        else if (c == B_IAC)
            pm_mode = M_IAC;
        else
            add_text(c);
    endfunction

    // Byte after IAC: a doubled IAC is a literal 0xFF, the four negotiation
    // verbs wait for an option byte, anything else is a two-byte command.
    function automatic void telnet_byte(input logic [7:0] c);
        pm_mode = M_TEXT;
        if (c == B_IAC)
            add_text(B_IAC);
        else if (c == B_WILL)
            pm_mode = M_WILL;
        else if (c == B_WONT)
            pm_mode = M_WONT;
        else if (c == B_DO)
            pm_mode = M_DO;
        else if (c == B_DONT)
            pm_mode = M_DONT;
        else
            add_event(K_TEL2, 8'h00, c, 8'h00, 7'd0);
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        logic [6:0] code_v;
        logic [7:0] cmd_v;
        code_v = 7'((int'(pm_code) % 10) * 10 + int'(c - B_ZERO));
        cmd_v = (pm_mode == M_WILL) ? B_WILL : (pm_mode == M_WONT) ? B_WONT :
                (pm_mode == M_DO) ? B_DO : B_DONT;
        case (pm_mode)
            M_ESC: begin
                if (c == B_LT) begin
                    pm_mode = M_OPEN;
                end else if (c == B_GT) begin
                    pm_mode = M_CLOSE;
                end else if (c == B_BAR) begin
                    pm_mode = M_TEXT;
                    add_event(K_ARGEND, 8'h00, 8'h00, 8'h00, 7'd0);
                end else begin
                    // A lone ESC is text, and the byte after it is parsed afresh.
                    pm_mode = M_TEXT;
                    add_text(B_ESC);
                    plain_byte(c);
                end
            end
            M_OPEN, M_CLOSE: begin
                if (!is_dec_char(c)) begin
                    pm_mode = M_TEXT;
                    pm_code = 7'd0;
                end else begin
                    pm_code = 7'(c - B_ZERO);
                    pm_mode = (pm_mode == M_OPEN) ? M_OPEN_N : M_CLOSE_N;
                end
            end
            M_OPEN_N: begin
                pm_mode = M_TEXT;
                // An open on a full stack is dropped silently.
                if (is_dec_char(c) && pm_depth < STACK_DEPTH) begin
                    pm_stack[pm_depth] = code_v;
                    pm_depth++;
                    add_event(K_OPEN, 8'h00, 8'h00, 8'h00, code_v);
                end
                pm_code = 7'd0;
            end
            M_CLOSE_N: begin
                pm_mode = M_TEXT;
                if (is_dec_char(c)) begin
                    // Close tag 10 arms the prompt check whether or not it matches.
                    if (code_v == PROMPT_CODE)
                        pm_mode = M_PTAG;
                    if (pm_depth > 0 && pm_stack[pm_depth - 1] == code_v) begin
                        pm_depth--;
                        add_event(K_CLOSE, 8'h00, 8'h00, 8'h00, code_v);
                    end
                end
                pm_code = 7'd0;
            end
            M_IAC: begin
                telnet_byte(c);
            end
            M_WILL, M_WONT, M_DO, M_DONT: begin
                pm_mode = M_TEXT;
                add_event(K_TEL3, 8'h00, cmd_v, c, 7'd0);
            end
            M_PTAG: begin
                if (c == B_IAC) begin
                    pm_mode = M_PIAC;
                end else begin
                    pm_mode = M_TEXT;
                    plain_byte(c);
                end
            end
            M_PIAC: begin
                if (c == B_GA) begin
                    pm_mode = M_TEXT;
                    add_event(K_PROMPT, 8'h00, 8'h00, 8'h00, 7'd0);
                end else begin
                    telnet_byte(c);
                end
            end
            default: begin
                pm_mode = M_TEXT;
                plain_byte(c);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted byte, checks every accepted
    // result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_stim_row r;
        t_result   want;
        if (!i_rst_n) begin
            pm_mode  = M_TEXT;
            pm_code  = 7'd0;
            pm_depth = 0;
        end else begin
            if (i_valid && o_ready) begin
                r = plan_q.pop_front();
                fresh_events.delete();
                parse_byte(i_rx_byte);
                // A hand-typed row replaces what the predictor gave; the
                // predictor still ran so its state stays in step.
                if (r.fixed) begin
                    fresh_events.delete();
                    if (r.has_ev)
                        fresh_events.push_back(r.ev);
                end
                if (fresh_events.size() > 0)
                    fresh_events[fresh_events.size() - 1].last = 1'b1;
                foreach (fresh_events[i])
                    pending_events.push_back(fresh_events[i]);
            end
            if (o_valid && i_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing expected",
                                              o_event_kind));
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", o_event_kind, want.kind);
                    check_field("text_byte", o_text_byte, want.text);
                    check_field("telnet_command", o_telnet_command, want.cmd);
                    check_field("telnet_option", o_telnet_option, want.opt);
                    check_field("tag_code", o_tag_code, want.code);
                    check_field("last_of_run", o_last_of_run, want.last);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when the sender asks.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= !idle_on || ($urandom_range(0, 99) >= 10);
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    task automatic send_row(input t_stim_row r);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        plan_q.push_back(r);
        i_valid   <= 1'b1;
        i_rx_byte <= r.rx;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
    endtask

    // Sender stops and waits until every expected result has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    task automatic send_tag(input logic [7:0] dir, input logic [6:0] code);
        send_row(row(B_ESC));
        send_row(row(dir));
        send_row(row(8'(B_ZERO + code / 10)));
        send_row(row(8'(B_ZERO + code % 10)));
    endtask

    // One random sequence: mostly well-formed tags, escapes and telnet
    // commands with random content, with some aborted tags and raw noise.
    task automatic send_sequence();
        int         pick;
        logic [7:0] b;
        logic [6:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom_range(0, 255));
                if (b == B_ESC || b == B_IAC)
                    b = 8'h61;
                send_row(row(b));
            end
        end else if (pick < 25) begin
            send_row(row(B_ESC));
            send_row(row(B_BAR));
        end else if (pick < 30) begin
            send_row(row(B_ESC));
            send_row(row(8'($urandom_range(0, 255))));
        end else if (pick < 45) begin
            code = ($urandom_range(0, 3) == 0) ? PROMPT_CODE : 7'($urandom_range(0, 99));
            send_tag(B_LT, code);
        end else if (pick < 65) begin
            // Mostly a close that matches the top, sometimes a stray one.
            if (pm_depth > 0 && $urandom_range(0, 4) != 0)
                code = pm_stack[pm_depth - 1];
            else
                code = 7'($urandom_range(0, 99));
            send_tag(B_GT, code);
        end else if (pick < 70) begin
            send_tag(B_GT, PROMPT_CODE);
            case ($urandom_range(0, 3))
                0, 1: begin
                    send_row(row(B_IAC));
                    send_row(row(B_GA));
                end
                2: begin
                    send_row(row(B_IAC));
                    send_row(row(8'($urandom_range(0, 255))));
                end
                default: begin
                    send_row(row(8'($urandom_range(0, 255))));
                end
            endcase
        end else if (pick < 80) begin
            send_row(row(B_IAC));
            case ($urandom_range(0, 3))
                0, 1: b = 8'(B_WILL + $urandom_range(0, 3));
                2: b = B_IAC;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_row(row(b));
            if (b >= B_WILL && b <= B_DONT)
                send_row(row(8'($urandom_range(0, 255))));
        end else if (pick < 85) begin
            // Tag broken off by a non-digit, before or after the first digit.
            send_row(row(B_ESC));
            send_row(row($urandom_range(0, 1) ? B_LT : B_GT));
            if ($urandom_range(0, 1))
                send_row(row(8'(B_ZERO + $urandom_range(0, 9))));
            do b = 8'($urandom_range(0, 255)); while (is_dec_char(b));
            send_row(row(b));
        end else if (pick < 87) begin
            // Open tags past the stack limit.
            repeat (STACK_DEPTH + 2 - pm_depth)
                send_tag(B_LT, 7'($urandom_range(0, 99)));
        end else begin
            repeat ($urandom_range(1, 3))
                send_row(row(8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // Directed part: extremes, each event kind and the special cases.
        directed = '{
            row(8'h00, 1, 1, K_TEXT, 8'h00),
            row(8'hFE, 1, 1, K_TEXT, 8'hFE),
            row(B_ESC, 1, 0),
            row(B_BAR, 1, 1, K_ARGEND),
            row(B_ESC),                        // lone ESC: two text results
            row(8'h41),
            row(B_ESC),
            row(B_LT),
            row(8'h31),
            row(8'h30, 1, 1, K_OPEN, 8'h00, 8'h00, 8'h00, 7'd10),
            row(8'h78),                        // text inside the open tag
            row(B_ESC),
            row(B_GT),
            row(8'h31),
            row(8'h30, 1, 1, K_CLOSE, 8'h00, 8'h00, 8'h00, 7'd10),
            row(B_IAC),
            row(B_GA, 1, 1, K_PROMPT),
            row(B_IAC),
            row(B_IAC, 1, 1, K_TEXT, 8'hFF),
            row(B_IAC),
            row(B_DONT, 1, 0),
            row(8'hFF, 1, 1, K_TEL3, 8'h00, B_DONT, 8'hFF),
            row(B_IAC),
            row(8'h00, 1, 1, K_TEL2, 8'h00, 8'h00),
            row(B_ESC),
            row(B_LT),
            row(8'h5A, 1, 0)                   // aborted open tag
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_row(directed[i]);
        drain_results();

        while (sent_items < ITEM_TARGET) begin
            // A stretch in the middle runs with no idling on either side.
            idle_on = (sent_items < 900) || (sent_items >= 1200);
            if (!hold_done && sent_items >= 700) begin
                hold_done = 1'b1;
                hold_requests++;
            end
            if (!pause_done && sent_items >= 1400) begin
                pause_done = 1'b1;
                drain_results();
            end
            send_sequence();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d results never came", pending_events.size()));
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/etp_pkg.sv
sv/etp_front.sv
sv/etp_queue.sv
sv/etp_back.sv
sv/escape_tag_and_telnet_parser_top.sv
tb/escape_tag_and_telnet_parser_top_tb.sv
